// ----- rtl/core/m4inv_pkg.sv -----
// m4inv_pkg: shared widths, types and the cofactor term table for the 4x4 inverse core
// no dependencies; used by m4inv_ctrl, m4inv_dp and matrix4_inverse_core
package m4inv_pkg;

    localparam int ELEM_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int MUL_W      = ELEM_W + 1;
    localparam int COF_W      = 3 * ELEM_W + 4;
    localparam int ACC_W      = 4 * ELEM_W + 8;
    localparam int DIV_W      = ACC_W + ELEM_W + 2;
    localparam int NCHUNK     = (COF_W + ELEM_W - 1) / ELEM_W;
    localparam int CPAD_W     = NCHUNK * ELEM_W;
    localparam int CH_W       = $clog2(NCHUNK);
    localparam int DIV_STEPS  = ELEM_W + 1;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int NTERMS     = 6;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_C_RA,
        ST_C_LA,
        ST_C_MAB,
        ST_C_MLO,
        ST_C_MHI,
        ST_C_ACC,
        ST_C_WR,
        ST_D_RA,
        ST_D_MUL,
        ST_D_ACC,
        ST_D_LATCH,
        ST_V_RD,
        ST_V_INIT,
        ST_V_DIV,
        ST_V_OUT,
        ST_V_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_AB,
        MUL_PLO,
        MUL_PHI,
        MUL_COF
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic            store_wr;
        logic            acc_clr;
        logic [3:0]      mat_addr;
        logic [3:0]      cof_addr;
        logic            a_load;
        logic            p_load;
        logic            prod_load;
        mul_sel_t        mul_sel;
        logic [CH_W-1:0] chunk;
        acc_op_t         acc_op;
        logic [CH_W-1:0] acc_sh;
        logic            cof_wr;
        logic            det_latch;
        logic            div_init;
        logic            div_step;
        logic            out_load;
        logic            last;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
    } dp_stat_t;

    typedef struct packed {
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic       neg;
    } term_t;

    // one signed triple product of the 3x3 minor behind cofactor k
    function automatic term_t cof_term(input logic [3:0] k, input logic [2:0] t);
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] rs0, rs1, rs2;
        logic [1:0] cs0, cs1, cs2;
        logic [1:0] pa, pb, pc;
        logic       pneg;
        term_t      res;
        row = k[1:0];
        col = k[3:2];
        rs0 = (row > 2'd0) ? 2'd0 : 2'd1;
        rs1 = (row > 2'd1) ? 2'd1 : 2'd2;
        rs2 = (row > 2'd2) ? 2'd2 : 2'd3;
        cs0 = (col > 2'd0) ? 2'd0 : 2'd1;
        cs1 = (col > 2'd1) ? 2'd1 : 2'd2;
        cs2 = (col > 2'd2) ? 2'd2 : 2'd3;
        case (t)
            3'd1:    begin pa = cs0; pb = cs2; pc = cs1; pneg = 1'b1; end
            3'd2:    begin pa = cs1; pb = cs0; pc = cs2; pneg = 1'b1; end
            3'd3:    begin pa = cs1; pb = cs2; pc = cs0; pneg = 1'b0; end
            3'd4:    begin pa = cs2; pb = cs0; pc = cs1; pneg = 1'b0; end
            3'd5:    begin pa = cs2; pb = cs1; pc = cs0; pneg = 1'b1; end
            default: begin pa = cs0; pb = cs1; pc = cs2; pneg = 1'b0; end
        endcase
        res.ia  = {pa, rs0};
        res.ib  = {pb, rs1};
        res.ic  = {pc, rs2};
        res.neg = pneg ^ row[0] ^ col[0];
        return res;
    endfunction

endpackage

// ----- rtl/core/matrix4_inverse_core.sv -----
// matrix4_inverse_core: 4x4 fixed-point matrix inverse by the adjugate, top level
// depends on m4inv_pkg, m4inv_ctrl and m4inv_dp
//
// usage:
//  - input channel s_*: sixteen Q16.16 elements per matrix, column-major, one per beat;
//    s_ready is high while loading
//  - after the sixteenth beat the block computes all sixteen cofactors on one shared
//    33x33 multiplier, then the determinant from the first column
//  - each result element then goes through cofactor read, divider setup, 33 steps of
//    the restoring divider, output load and beat; the divider steps are skipped
//    when the determinant is zero
//  - output channel m_*: sixteen beats, column-major, m_last on the sixteenth;
//    m_singular with zero data when the determinant is zero, m_saturated when clipped
//  - a stalled receiver holds the current beat; the divider waits until it is taken
//  - s_ready stays low from the sixteenth input beat until the last result is taken
//  - aresetn (synchronous, active low) returns to loading with an empty element count
module matrix4_inverse_core
    import m4inv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ELEM_W-1:0] s_element,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ELEM_W-1:0] m_inverse_element,
    output logic              m_last,
    output logic              m_singular,
    output logic              m_saturated
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    m4inv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    m4inv_dp u_dp (
        .aclk              (aclk),
        .cmd               (cmd),
        .s_element         (s_element),
        .stat              (stat),
        .m_inverse_element (m_inverse_element),
        .m_last            (m_last),
        .m_singular        (m_singular),
        .m_saturated       (m_saturated)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and result phases overlap");

    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready)
        else $error("input not reopened after last beat");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> (m_inverse_element == '0) && !m_saturated)
        else $error("singular beat carries data");

    a_load_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("input reopened mid-matrix");

endmodule

// ----- rtl/core/m4inv_ctrl.sv -----
// m4inv_ctrl: sequencer for load, cofactor, determinant and division phases
// depends on m4inv_pkg; drives m4inv_dp through dp_cmd_t
module m4inv_ctrl
    import m4inv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [3:0]        load_cnt_reg, load_cnt_next;
    logic [3:0]        idx_reg, idx_next;
    logic [2:0]        term_reg, term_next;
    logic [CH_W-1:0]   chunk_reg, chunk_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    term_t             tm;

    assign tm = cof_term(idx_reg, term_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            idx_reg      <= '0;
            term_reg     <= '0;
            chunk_reg    <= '0;
            dcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            idx_reg      <= idx_next;
            term_reg     <= term_next;
            chunk_reg    <= chunk_next;
            dcnt_reg     <= dcnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        idx_next      = idx_reg;
        term_next     = term_reg;
        chunk_next    = chunk_reg;
        dcnt_next     = dcnt_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = MUL_AB;
        cmd.acc_op    = ACC_NONE;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready      = 1'b1;
                cmd.mat_addr = load_cnt_reg;
                if (s_valid) begin
                    cmd.store_wr  = 1'b1;
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15) begin
                        cmd.acc_clr = 1'b1;
                        idx_next    = '0;
                        term_next   = '0;
                        state_next  = ST_C_RA;
                    end
                end
            end
            ST_C_RA: begin
                cmd.mat_addr = tm.ia;
                state_next   = ST_C_LA;
            end
            ST_C_LA: begin
                cmd.a_load   = 1'b1;
                cmd.mat_addr = tm.ib;
                state_next   = ST_C_MAB;
            end
            ST_C_MAB: begin
                cmd.mul_sel  = MUL_AB;
                cmd.p_load   = 1'b1;
                cmd.mat_addr = tm.ic;
                state_next   = ST_C_MLO;
            end
            ST_C_MLO: begin
                cmd.mul_sel   = MUL_PLO;
                cmd.prod_load = 1'b1;
                cmd.mat_addr  = tm.ic;
                state_next    = ST_C_MHI;
            end
            ST_C_MHI: begin
                cmd.mul_sel   = MUL_PHI;
                cmd.prod_load = 1'b1;
                cmd.mat_addr  = tm.ic;
                cmd.acc_op    = tm.neg ? ACC_SUB : ACC_ADD;
                cmd.acc_sh    = '0;
                state_next    = ST_C_ACC;
            end
            ST_C_ACC: begin
                cmd.acc_op = tm.neg ? ACC_SUB : ACC_ADD;
                cmd.acc_sh = CH_W'(1);
                if (term_reg == 3'(NTERMS - 1)) begin
                    state_next = ST_C_WR;
                end else begin
                    term_next  = term_reg + 3'd1;
                    state_next = ST_C_RA;
                end
            end
            ST_C_WR: begin
                cmd.cof_wr   = 1'b1;
                cmd.cof_addr = idx_reg;
                cmd.acc_clr  = 1'b1;
                term_next    = '0;
                if (idx_reg == 4'd15) begin
                    idx_next   = '0;
                    state_next = ST_D_RA;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = ST_C_RA;
                end
            end
            ST_D_RA: begin
                cmd.mat_addr = idx_reg;
                cmd.cof_addr = idx_reg;
                chunk_next   = '0;
                state_next   = ST_D_MUL;
            end
            ST_D_MUL: begin
                cmd.mat_addr  = idx_reg;
                cmd.cof_addr  = idx_reg;
                cmd.mul_sel   = MUL_COF;
                cmd.chunk     = chunk_reg;
                cmd.prod_load = 1'b1;
                if (chunk_reg != '0) begin
                    cmd.acc_op = ACC_ADD;
                    cmd.acc_sh = chunk_reg - CH_W'(1);
                end
                if (chunk_reg == CH_W'(NCHUNK - 1)) begin
                    state_next = ST_D_ACC;
                end else begin
                    chunk_next = chunk_reg + CH_W'(1);
                end
            end
            ST_D_ACC: begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = CH_W'(NCHUNK - 1);
                if (idx_reg == 4'd3) begin
                    idx_next   = '0;
                    state_next = ST_D_LATCH;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = ST_D_RA;
                end
            end
            ST_D_LATCH: begin
                cmd.det_latch = 1'b1;
                state_next    = ST_V_RD;
            end
            ST_V_RD: begin
                cmd.cof_addr = {idx_reg[1:0], idx_reg[3:2]};
                state_next   = ST_V_INIT;
            end
            ST_V_INIT: begin
                cmd.cof_addr = {idx_reg[1:0], idx_reg[3:2]};
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = stat.det_zero ? ST_V_OUT : ST_V_DIV;
            end
            ST_V_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_V_OUT;
                end
            end
            ST_V_OUT: begin
                cmd.out_load = 1'b1;
                cmd.last     = (idx_reg == 4'd15);
                state_next   = ST_V_WAIT;
            end
            ST_V_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == 4'd15) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = ST_V_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/core/m4inv_dp.sv -----
// m4inv_dp: element and cofactor stores, shared multiplier, accumulator and divider
// depends on m4inv_pkg; sequenced by m4inv_ctrl
module m4inv_dp
    import m4inv_pkg::*;
(
    input  logic              aclk,
    input  dp_cmd_t           cmd,
    input  logic [ELEM_W-1:0] s_element,
    output dp_stat_t          stat,
    output logic [ELEM_W-1:0] m_inverse_element,
    output logic              m_last,
    output logic              m_singular,
    output logic              m_saturated
);

    logic        [ELEM_W-1:0]   mat_mem [16];
    logic signed [COF_W-1:0]    cof_mem [16];
    logic signed [ELEM_W-1:0]   rd_reg;
    logic signed [COF_W-1:0]    cof_rd_reg;
    logic signed [ELEM_W-1:0]   a_reg;
    logic        [2*ELEM_W-1:0] p_reg;
    logic signed [2*MUL_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic        [ACC_W-1:0]    det_abs_reg;
    logic                       det_neg_reg;
    logic                       det_zero_reg;
    logic        [DIV_W-1:0]    rem_reg;
    logic        [DIV_W-1:0]    dvs_reg;
    logic        [ELEM_W:0]     q_reg;
    logic                       qneg_reg;
    logic        [ELEM_W-1:0]   out_elem_reg;
    logic                       out_last_reg;
    logic                       out_sing_reg;
    logic                       out_sat_reg;

    logic signed [MUL_W-1:0]    mul_x;
    logic signed [MUL_W-1:0]    mul_y;
    logic signed [2*MUL_W-1:0]  mul_res;
    logic signed [CPAD_W-1:0]   cof_pad;
    logic        [ELEM_W-1:0]   chunk_bits;
    logic signed [ACC_W-1:0]    addend;
    logic                       c_neg;
    logic        [COF_W-1:0]    c_abs;
    logic        [ELEM_W-1:0]   q_lo;
    logic                       q_big;
    logic                       sat_c;
    logic        [ELEM_W-1:0]   res_c;

    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};
    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};

    assign cof_pad    = CPAD_W'(cof_rd_reg);
    assign chunk_bits = cof_pad[int'(cmd.chunk) * ELEM_W +: ELEM_W];
    assign mul_y      = MUL_W'(rd_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_AB:  mul_x = MUL_W'(a_reg);
            MUL_PLO: mul_x = {1'b0, p_reg[ELEM_W-1:0]};
            MUL_PHI: mul_x = {p_reg[2*ELEM_W-1], p_reg[2*ELEM_W-1:ELEM_W]};
            default: begin
                if (cmd.chunk == CH_W'(NCHUNK - 1)) begin
                    mul_x = {chunk_bits[ELEM_W-1], chunk_bits};
                end else begin
                    mul_x = {1'b0, chunk_bits};
                end
            end
        endcase
    end

    assign mul_res = mul_x * mul_y;
    assign addend  = ACC_W'(prod_reg) <<< (int'(cmd.acc_sh) * ELEM_W);

    assign c_neg = cof_rd_reg[COF_W-1];
    assign c_abs = c_neg ? COF_W'(-cof_rd_reg) : COF_W'(cof_rd_reg);

    assign q_lo  = q_reg[ELEM_W-1:0];
    assign q_big = q_reg[ELEM_W];

    always_comb begin
        if (qneg_reg) begin
            sat_c = q_big || (q_lo > ELEM_MIN);
            res_c = sat_c ? ELEM_MIN : (~q_lo + ELEM_W'(1));
        end else begin
            sat_c = q_big || q_lo[ELEM_W-1];
            res_c = sat_c ? ELEM_MAX : q_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            mat_mem[cmd.mat_addr] <= s_element;
        end
        if (cmd.cof_wr) begin
            cof_mem[cmd.cof_addr] <= acc_reg[COF_W-1:0];
        end
        rd_reg     <= mat_mem[cmd.mat_addr];
        cof_rd_reg <= cof_mem[cmd.cof_addr];
        if (cmd.a_load) begin
            a_reg <= rd_reg;
        end
        if (cmd.p_load) begin
            p_reg <= mul_res[2*ELEM_W-1:0];
        end
        if (cmd.prod_load) begin
            prod_reg <= mul_res;
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else begin
            case (cmd.acc_op)
                ACC_ADD: acc_reg <= acc_reg + addend;
                ACC_SUB: acc_reg <= acc_reg - addend;
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.det_latch) begin
            det_neg_reg  <= acc_reg[ACC_W-1];
            det_abs_reg  <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            det_zero_reg <= (acc_reg == '0);
        end
        if (cmd.div_init) begin
            // rounded quotient: (2|C|*2^2F + |D|) / (2|D|)
            rem_reg  <= (DIV_W'(c_abs) << (2 * FRAC_W + 1)) + DIV_W'(det_abs_reg);
            dvs_reg  <= DIV_W'(det_abs_reg) << (ELEM_W + 1);
            q_reg    <= '0;
            qneg_reg <= c_neg ^ det_neg_reg;
        end else if (cmd.div_step) begin
            if (rem_reg >= dvs_reg) begin
                rem_reg <= rem_reg - dvs_reg;
                q_reg   <= {q_reg[ELEM_W-1:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[ELEM_W-1:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.out_load) begin
            out_last_reg <= cmd.last;
            out_sing_reg <= det_zero_reg;
            if (det_zero_reg) begin
                out_elem_reg <= '0;
                out_sat_reg  <= 1'b0;
            end else begin
                out_elem_reg <= res_c;
                out_sat_reg  <= sat_c;
            end
        end
    end

    assign stat.det_zero     = det_zero_reg;
    assign m_inverse_element = out_elem_reg;
    assign m_last            = out_last_reg;
    assign m_singular        = out_sing_reg;
    assign m_saturated       = out_sat_reg;

endmodule

// ----- bench/tb_matrix4_inverse_core.sv -----
// tb_matrix4_inverse_core: self-checking bench for the streaming 4x4 fixed-point inverse core
// depends on m4inv_pkg and matrix4_inverse_core; predicts each inverse element in wide integers
module tb_matrix4_inverse_core;
    import m4inv_pkg::*;

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic [ELEM_W-1:0] value;
        logic              last;
        logic              singular;
        logic              saturated;
    } inv_beat_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [ELEM_W-1:0] s_element;
    logic              m_valid;
    logic              m_ready;
    logic [ELEM_W-1:0] m_inverse_element;
    logic              m_last;
    logic              m_singular;
    logic              m_saturated;

    inv_beat_t         inverse_q[$];
    logic [ELEM_W-1:0] loaded[16];
    int                load_idx;
    int                errors;
    bit                idle_en;
    int                hold_cycles;
    int                rx_gap;

    matrix4_inverse_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_element(s_element),
        .m_valid(m_valid), .m_ready(m_ready), .m_inverse_element(m_inverse_element),
        .m_last(m_last), .m_singular(m_singular), .m_saturated(m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[matrix4_inverse_core] ERROR");
        $finish;
    end

    function automatic big_t el(int row, int col);
        big_t v;
        v = big_t'($signed(loaded[(row & 3) + 4 * (col & 3)]));
        return v;
    endfunction

    function automatic big_t minor_cofactor(int row, int col);
        int   rs[3];
        int   cs[3];
        int   n;
        big_t t0, t1, t2, d;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != row) begin rs[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != col) begin cs[n] = i; n++; end
        t0 = el(rs[0], cs[0]) * (el(rs[1], cs[1]) * el(rs[2], cs[2])
                               - el(rs[1], cs[2]) * el(rs[2], cs[1]));
        t1 = el(rs[0], cs[1]) * (el(rs[1], cs[0]) * el(rs[2], cs[2])
                               - el(rs[1], cs[2]) * el(rs[2], cs[0]));
        t2 = el(rs[0], cs[2]) * (el(rs[1], cs[0]) * el(rs[2], cs[1])
                               - el(rs[1], cs[1]) * el(rs[2], cs[0]));
        d = t0 - t1 + t2;
        return ((row + col) & 1) ? -d : d;
    endfunction

    task automatic predict_inverse();
        big_t      cof[16];
        big_t      det, adet, num, q;
        big_t      lim_pos, lim_neg;
        inv_beat_t b;
        bit        neg;
        for (int k = 0; k < 16; k++) cof[k] = minor_cofactor(k & 3, k >> 2);
        det = 0;
        for (int k = 0; k < 4; k++) det = det + el(k, 0) * cof[k];
        adet = (det < 0) ? -det : det;
        lim_pos = (big_t'(1) <<< (ELEM_W - 1)) - 1;
        lim_neg = big_t'(1) <<< (ELEM_W - 1);
        for (int k = 0; k < 16; k++) begin
            b.last = (k == 15);
            b.singular = (det == 0);
            b.saturated = 1'b0;
            b.value = '0;
            if (det != 0) begin
                num = cof[(k >> 2) + 4 * (k & 3)];
                neg = (num < 0) != (det < 0);
                if (num < 0) num = -num;
                num = num <<< (2 * FRAC_W);
                q = (2 * num + adet) / (2 * adet);
                if (neg) begin
                    if (q > lim_neg) begin b.saturated = 1'b1; q = lim_neg; end
                    q = -q;
                end else if (q > lim_pos) begin
                    b.saturated = 1'b1;
                    q = lim_pos;
                end
                b.value = q[ELEM_W-1:0];
            end
            inverse_q.push_back(b);
        end
    endtask

    task automatic report(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (inverse_q.size() == 0) begin
                report("unexpected beat", m_inverse_element, '0);
            end else begin
                inv_beat_t w;
                w = inverse_q.pop_front();
                if (m_inverse_element !== w.value) report("element", m_inverse_element, w.value);
                if (m_last !== w.last) report("last", ELEM_W'(m_last), ELEM_W'(w.last));
                if (m_singular !== w.singular)
                    report("singular", ELEM_W'(m_singular), ELEM_W'(w.singular));
                if (m_saturated !== w.saturated)
                    report("saturated", ELEM_W'(m_saturated), ELEM_W'(w.saturated));
            end
        end
    end

    // receiver: long hold-off when requested, else random stall bursts while idle_en is set
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            rx_gap <= $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_element(logic [ELEM_W-1:0] v);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_element <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        loaded[load_idx] = v;
        load_idx = (load_idx + 1) & 15;
        if (load_idx == 0) predict_inverse();
    endtask

    function automatic logic [ELEM_W-1:0] rand_elem(int kind);
        case (kind)
            0: return $urandom;
            1: return ELEM_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return ELEM_W'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
        endcase
    endfunction

    task automatic test_diagonal_extremes();
        logic [ELEM_W-1:0] diag[4];
        diag[0] = 32'h0000_0001;
        diag[1] = 32'hffff_ffff;
        diag[2] = 32'h7fff_ffff;
        diag[3] = 32'h8000_0000;
        for (int k = 0; k < 16; k++) send_element((k % 5 == 0) ? diag[k / 5] : '0);
    endtask

    task automatic test_zero_matrix();
        for (int k = 0; k < 16; k++) send_element('0);
    endtask

    task automatic test_random_matrices(int count);
        logic [ELEM_W-1:0] col[4];
        int kind;
        for (int m = 0; m < count; m++) begin
            kind = $urandom_range(0, 2);
            for (int k = 0; k < 16; k++) begin
                if (m % 4 == 3 && k >= 12) send_element(col[k - 12]);
                else begin
                    if (k < 4) col[k] = rand_elem(kind);
                    send_element((k < 4) ? col[k] : rand_elem(kind));
                end
            end
        end
    endtask

    task automatic test_output_holdoff();
        @(posedge aclk);
        hold_cycles <= 3000;
        test_random_matrices(2);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_element = '0;
        m_ready = 1'b0;
        hold_cycles = 0;
        rx_gap = 0;
        load_idx = 0;
        errors = 0;
        idle_en = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_diagonal_extremes();
        test_zero_matrix();
        test_random_matrices(3);
        test_output_holdoff();
        idle_en = 1'b0;
        test_random_matrices(2);
        s_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("[matrix4_inverse_core] OK");
        else $display("[matrix4_inverse_core] ERROR");
        $finish;
    end

endmodule
